FILE: design/icv_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// icv_pkg
// Shared types, widths and codes for the impulse collision velocity block.
// ----------------------------------------------------------------------------
package icv_pkg;

  localparam int unsigned ONE_Q16       = 65536;
  localparam int unsigned QUEUE_DEPTH_D = 4;
  localparam int unsigned DIV_STEPS     = 17;

  // Widths of the intermediate results
  localparam int unsigned PRD_W = 57;  // (1+e) * dq
  localparam int unsigned P_W   = 42;  // impulse magnitude p
  localparam int unsigned A_W   = 44;  // p * n_i, rescaled
  localparam int unsigned M_W   = 62;  // a * f
  localparam int unsigned R_W   = 47;  // velocity plus delta

  typedef enum logic [1:0] {
    OC_APPLIED    = 2'd0,
    OC_SEPARATING = 2'd1,
    OC_EQUAL      = 2'd2,
    OC_NO_MASS    = 2'd3
  } outcome_t;

  typedef logic [2:0][31:0] vec3_t;
  typedef logic [2:0][17:0] nrm3_t;

  // Classified contact handed from front to back
  typedef struct packed {
    vec3_t            v1;
    vec3_t            v2;
    nrm3_t            n;
    logic [31:0]      im1;
    logic [31:0]      im2;
    logic [32:0]      sum;
    outcome_t         outcome;
    logic [PRD_W-1:0] prod;
  } entry_t;

endpackage
`default_nettype wire

FILE: design/icv_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// icv_front
// Accepts contacts, forms normal speeds, classifies and scales the impulse.
// ----------------------------------------------------------------------------
module icv_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire icv_pkg::vec3_t in_v1,
  input  wire icv_pkg::vec3_t in_v2,
  input  wire icv_pkg::nrm3_t in_n,
  input  wire logic [31:0]    in_im1,
  input  wire logic [31:0]    in_im2,
  input  wire logic [17:0]    restitution,
  input  wire logic [30:0]    speed_tolerance,
  input  wire logic           queue_full,
  output logic                push,
  output icv_pkg::entry_t     push_entry
);
  import icv_pkg::*;

  logic        en;
  logic [3:0]  vld;

  // stage 0: captured beat
  vec3_t       s0_v1, s0_v2;
  nrm3_t       s0_n;
  logic [31:0] s0_im1, s0_im2;

  // stage 1: products
  vec3_t       s1_v1, s1_v2;
  nrm3_t       s1_n;
  logic [31:0] s1_im1, s1_im2;
  logic [32:0] s1_sum;
  logic signed [49:0] s1_p1 [3];
  logic signed [49:0] s1_p2 [3];
  logic signed [49:0] p1_c [3];
  logic signed [49:0] p2_c [3];

  // stage 2: dot products and difference
  vec3_t       s2_v1, s2_v2;
  nrm3_t       s2_n;
  logic [31:0] s2_im1, s2_im2;
  logic [32:0] s2_sum;
  logic signed [51:0] s2_s1, s2_s2;
  logic signed [52:0] s2_d;
  logic signed [51:0] s1_c, s2_c;

  // stage 3 combinational
  logic signed [53:0] tq, s1w, s2w, dw, ad;
  logic signed [36:0] dq;
  logic signed [19:0] coef;
  logic signed [PRD_W-1:0] prod_c;
  outcome_t oc_c;

  // Advance the whole front unless the last beat is blocked
  assign en       = !(vld[3] && queue_full);
  assign in_stall = !en;
  assign push     = vld[3] && !queue_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[2:0], in_valid};
    end
  end

  // Form the six velocity by normal products and sum them into the two normal speeds
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      p1_c[i] = $signed(s0_v1[i]) * $signed(s0_n[i]);
      p2_c[i] = $signed(s0_v2[i]) * $signed(s0_n[i]);
    end
    s1_c = $signed({{2{s1_p1[0][49]}}, s1_p1[0]}) + $signed({{2{s1_p1[1][49]}}, s1_p1[1]})
         + $signed({{2{s1_p1[2][49]}}, s1_p1[2]});
    s2_c = $signed({{2{s1_p2[0][49]}}, s1_p2[0]}) + $signed({{2{s1_p2[1][49]}}, s1_p2[1]})
         + $signed({{2{s1_p2[2][49]}}, s1_p2[2]});
  end

  // Classify the contact and scale the relative speed by 1+e
  always_comb begin
    tq   = $signed({7'b0, speed_tolerance, 16'b0});
    s1w  = $signed({{2{s2_s1[51]}}, s2_s1});
    s2w  = $signed({{2{s2_s2[51]}}, s2_s2});
    dw   = $signed({s2_d[52], s2_d});
    ad   = dw[53] ? -dw : dw;
    if (s1w >= -tq && s2w <= tq) begin
      oc_c = OC_SEPARATING;
    end else if (ad <= tq) begin
      oc_c = OC_EQUAL;
    end else if (s2_sum == '0) begin
      oc_c = OC_NO_MASS;
    end else begin
      oc_c = OC_APPLIED;
    end
    dq     = s2_d[52:16];
    coef   = $signed({2'b0, restitution} + 20'(ONE_Q16));
    prod_c = dq * coef;
  end

  // Hold payload while stalled
  always_ff @(posedge clk) begin
    if (en) begin
      s0_v1  <= in_v1;
      s0_v2  <= in_v2;
      s0_n   <= in_n;
      s0_im1 <= in_im1;
      s0_im2 <= in_im2;

      s1_v1  <= s0_v1;
      s1_v2  <= s0_v2;
      s1_n   <= s0_n;
      s1_im1 <= s0_im1;
      s1_im2 <= s0_im2;
      s1_sum <= {1'b0, s0_im1} + {1'b0, s0_im2};
      for (int i = 0; i < 3; i++) begin
        s1_p1[i] <= p1_c[i];
        s1_p2[i] <= p2_c[i];
      end

      s2_v1  <= s1_v1;
      s2_v2  <= s1_v2;
      s2_n   <= s1_n;
      s2_im1 <= s1_im1;
      s2_im2 <= s1_im2;
      s2_sum <= s1_sum;
      s2_s1  <= s1_c;
      s2_s2  <= s2_c;
      s2_d   <= $signed({s1_c[51], s1_c}) - $signed({s2_c[51], s2_c});

      push_entry.v1      <= s2_v1;
      push_entry.v2      <= s2_v2;
      push_entry.n       <= s2_n;
      push_entry.im1     <= s2_im1;
      push_entry.im2     <= s2_im2;
      push_entry.sum     <= s2_sum;
      push_entry.outcome <= oc_c;
      push_entry.prod    <= prod_c;
    end
  end

endmodule
`default_nettype wire

FILE: design/icv_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// icv_queue
// Short first-in first-out queue of classified contacts.
// ----------------------------------------------------------------------------
module icv_queue #(
  parameter int unsigned DEPTH = icv_pkg::QUEUE_DEPTH_D
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire icv_pkg::entry_t push_entry,
  input  wire logic            pop,
  output icv_pkg::entry_t      pop_entry,
  output logic                 full,
  output logic                 empty
);
  import icv_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  entry_t          slots [DEPTH];
  logic [PW-1:0]   wr_ptr, rd_ptr;
  logic [CW-1:0]   count;

  assign full      = (count == CW'(DEPTH));
  assign empty     = (count == '0);
  assign pop_entry = slots[rd_ptr];

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule
`default_nettype wire

FILE: design/icv_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// icv_back
// Mass split by pipelined division, impulse per axis, velocity update.
// ----------------------------------------------------------------------------
module icv_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire icv_pkg::entry_t pop_entry,
  input  wire logic            queue_empty,
  output logic                 pop,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output icv_pkg::vec3_t       out_v1,
  output icv_pkg::vec3_t       out_v2,
  output logic [1:0]           out_outcome
);
  import icv_pkg::*;

  typedef struct packed {
    vec3_t          v1;
    vec3_t          v2;
    nrm3_t          n;
    outcome_t       outcome;
    logic [P_W-1:0] p;
    logic [32:0]    sum;
    logic [16:0]    lo1;
    logic [16:0]    lo2;
    logic [32:0]    rem1;
    logic [32:0]    rem2;
    logic [16:0]    q1;
    logic [16:0]    q2;
  } div_t;

  // One restoring division step on both mass fractions
  function automatic div_t div_step(input div_t s);
    div_t       r;
    logic [33:0] t1, t2;
    logic        g1, g2;
    r  = s;
    t1 = {s.rem1, s.lo1[16]};
    t2 = {s.rem2, s.lo2[16]};
    g1 = (t1 >= {1'b0, s.sum});
    g2 = (t2 >= {1'b0, s.sum});
    r.rem1 = g1 ? 33'(t1 - {1'b0, s.sum}) : t1[32:0];
    r.rem2 = g2 ? 33'(t2 - {1'b0, s.sum}) : t2[32:0];
    r.q1   = {s.q1[15:0], g1};
    r.q2   = {s.q2[15:0], g2};
    r.lo1  = {s.lo1[15:0], 1'b0};
    r.lo2  = {s.lo2[15:0], 1'b0};
    return r;
  endfunction

  function automatic logic [31:0] sat32(input logic signed [R_W-1:0] x);
    logic [31:0] r;
    if (x > $signed(R_W'(32'sh7fffffff))) begin
      r = 32'h7fffffff;
    end else if (x < -$signed(R_W'(64'h80000000))) begin
      r = 32'h80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  logic                  en;
  logic [DIV_STEPS:0]    dvld;
  div_t                  dst [DIV_STEPS+1];
  div_t                  init_c;
  logic [48:0]           num1, num2;
  logic signed [PRD_W:0] negp;

  // axis stage
  logic                  a_vld;
  vec3_t                 a_v1, a_v2;
  outcome_t              a_oc;
  logic [16:0]           a_f1, a_f2;
  logic signed [A_W-1:0] a_val [3];
  logic signed [A_W+15:0] an_c [3];

  // product stage
  logic                  m_vld;
  vec3_t                 m_v1, m_v2;
  outcome_t              m_oc;
  logic signed [M_W-1:0] m1 [3];
  logic signed [M_W-1:0] m2 [3];
  logic signed [M_W-1:0] m1_c [3];
  logic signed [M_W-1:0] m2_c [3];

  logic signed [R_W-1:0] r1_c [3];
  logic signed [R_W-1:0] r2_c [3];

  // Advance everything unless the result beat is held
  assign en  = !(out_valid && out_stall);
  assign pop = en && !queue_empty;

  // Set up numerators (im << 16) + sum/2 and the impulse p
  always_comb begin
    num1 = {1'b0, pop_entry.im1, 16'b0} + {17'b0, pop_entry.sum[32:1]};
    num2 = {1'b0, pop_entry.im2, 16'b0} + {17'b0, pop_entry.sum[32:1]};
    negp = -$signed({pop_entry.prod[PRD_W-1], pop_entry.prod});
    init_c.v1      = pop_entry.v1;
    init_c.v2      = pop_entry.v2;
    init_c.n       = pop_entry.n;
    init_c.outcome = pop_entry.outcome;
    init_c.p       = negp[PRD_W:16];
    init_c.sum     = pop_entry.sum;
    init_c.lo1     = num1[16:0];
    init_c.lo2     = num2[16:0];
    init_c.rem1    = {1'b0, num1[48:17]};
    init_c.rem2    = {1'b0, num2[48:17]};
    init_c.q1      = '0;
    init_c.q2      = '0;
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      an_c[i] = $signed(dst[DIV_STEPS].p) * $signed(dst[DIV_STEPS].n[i]);
      m1_c[i] = a_val[i] * $signed({1'b0, a_f1});
      m2_c[i] = a_val[i] * $signed({1'b0, a_f2});
      r1_c[i] = $signed({{(R_W-32){m_v1[i][31]}}, m_v1[i]})
              + $signed(m1[i][M_W-1:16]);
      r2_c[i] = $signed({{(R_W-32){m_v2[i][31]}}, m_v2[i]})
              - $signed(m2[i][M_W-1:16]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dvld      <= '0;
      a_vld     <= 1'b0;
      m_vld     <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      dvld      <= {dvld[DIV_STEPS-1:0], !queue_empty};
      a_vld     <= dvld[DIV_STEPS];
      m_vld     <= a_vld;
      out_valid <= m_vld;
    end
  end

  // Hold payload while stalled
  always_ff @(posedge clk) begin
    if (en) begin
      dst[0] <= init_c;
      for (int k = 0; k < DIV_STEPS; k++) begin
        dst[k+1] <= div_step(dst[k]);
      end

      a_v1 <= dst[DIV_STEPS].v1;
      a_v2 <= dst[DIV_STEPS].v2;
      a_oc <= dst[DIV_STEPS].outcome;
      a_f1 <= dst[DIV_STEPS].q1;
      a_f2 <= dst[DIV_STEPS].q2;
      for (int i = 0; i < 3; i++) begin
        a_val[i] <= an_c[i][A_W+15:16];
      end

      m_v1 <= a_v1;
      m_v2 <= a_v2;
      m_oc <= a_oc;
      for (int i = 0; i < 3; i++) begin
        m1[i] <= m1_c[i];
        m2[i] <= m2_c[i];
      end

      out_outcome <= m_oc;
      for (int i = 0; i < 3; i++) begin
        if (m_oc == OC_APPLIED) begin
          out_v1[i] <= sat32(r1_c[i]);
          out_v2[i] <= sat32(r2_c[i]);
        end else begin
          out_v1[i] <= m_v1[i];
          out_v2[i] <= m_v2[i];
        end
      end
    end
  end

endmodule
`default_nettype wire

FILE: design/impulse_collision_velocity.sv
`default_nettype none
// ----------------------------------------------------------------------------
// impulse_collision_velocity
// Impulse response of one contact between two bodies, fixed point.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+-----------------------------------------
//  input    | in_valid / in_stall  | two velocities, normal, two inverse masses
//  output   | out_valid / out_stall| two new velocities, outcome
//  config   | APB, pready tied high| restitution (0x0), speed_tolerance (0x4)
//
// One beat per cycle sustained while no stall holds it; each beat passes the
// front, the queue, then the back end with its 17-step pipelined divider that
// forms the mass fractions. Reset is synchronous and clears valids and queue
// pointers; it sets restitution to 1.0 and clears speed_tolerance. A held
// output stalls the back end; the front keeps accepting until the queue fills.
// ----------------------------------------------------------------------------
module impulse_collision_velocity #(
  parameter int unsigned QUEUE_DEPTH = icv_pkg::QUEUE_DEPTH_D
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] first_vel_x,
  input  wire logic [31:0] first_vel_y,
  input  wire logic [31:0] first_vel_z,
  input  wire logic [31:0] second_vel_x,
  input  wire logic [31:0] second_vel_y,
  input  wire logic [31:0] second_vel_z,
  input  wire logic [17:0] normal_x,
  input  wire logic [17:0] normal_y,
  input  wire logic [17:0] normal_z,
  input  wire logic [31:0] first_inv_mass,
  input  wire logic [31:0] second_inv_mass,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      first_out_x,
  output logic [31:0]      first_out_y,
  output logic [31:0]      first_out_z,
  output logic [31:0]      second_out_x,
  output logic [31:0]      second_out_y,
  output logic [31:0]      second_out_z,
  output logic [1:0]       outcome
);
  import icv_pkg::*;

  localparam logic REG_RESTITUTION = 1'b0;
  localparam logic REG_TOLERANCE   = 1'b1;

  logic [17:0] restitution;
  logic [30:0] speed_tolerance;
  logic        wr_en;

  vec3_t  in_v1, in_v2, res_v1, res_v2;
  nrm3_t  in_n;
  entry_t push_entry, pop_entry;
  logic   push, pop, q_full, q_empty;

  // Register file
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      restitution     <= 18'(ONE_Q16);
      speed_tolerance <= '0;
    end else if (wr_en) begin
      if (paddr[2] == REG_RESTITUTION) begin
        restitution <= pwdata[17:0];
      end else begin
        speed_tolerance <= pwdata[30:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_TOLERANCE) begin
      prdata = {1'b0, speed_tolerance};
    end else begin
      prdata = {14'b0, restitution};
    end
  end

  // Gather the beat into vectors
  assign in_v1 = {first_vel_z, first_vel_y, first_vel_x};
  assign in_v2 = {second_vel_z, second_vel_y, second_vel_x};
  assign in_n  = {normal_z, normal_y, normal_x};

  icv_front u_front (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_v1           (in_v1),
    .in_v2           (in_v2),
    .in_n            (in_n),
    .in_im1          (first_inv_mass),
    .in_im2          (second_inv_mass),
    .restitution     (restitution),
    .speed_tolerance (speed_tolerance),
    .queue_full      (q_full),
    .push            (push),
    .push_entry      (push_entry)
  );

  icv_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .full       (q_full),
    .empty      (q_empty)
  );

  icv_back u_back (
    .clk         (clk),
    .rst         (rst),
    .pop_entry   (pop_entry),
    .queue_empty (q_empty),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_v1      (res_v1),
    .out_v2      (res_v2),
    .out_outcome (outcome)
  );

  // Split result vectors onto ports
  assign first_out_x  = res_v1[0];
  assign first_out_y  = res_v1[1];
  assign first_out_z  = res_v1[2];
  assign second_out_x = res_v2[0];
  assign second_out_y = res_v2[1];
  assign second_out_z = res_v2[2];

endmodule
`default_nettype wire

FILE: tb/icv_checker.sv
// ----------------------------------------------------------------------------
// icv_checker
// Watches the contact and result channels of the impulse collision velocity
// block, predicts each result from the accepted contact and the register
// values in force, and compares the results field by field in order.
// ----------------------------------------------------------------------------
module icv_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic [17:0] restitution,
  input  logic [30:0] speed_tolerance,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [31:0] first_vel_x,
  input  logic [31:0] first_vel_y,
  input  logic [31:0] first_vel_z,
  input  logic [31:0] second_vel_x,
  input  logic [31:0] second_vel_y,
  input  logic [31:0] second_vel_z,
  input  logic [17:0] normal_x,
  input  logic [17:0] normal_y,
  input  logic [17:0] normal_z,
  input  logic [31:0] first_inv_mass,
  input  logic [31:0] second_inv_mass,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] first_out_x,
  input  logic [31:0] first_out_y,
  input  logic [31:0] first_out_z,
  input  logic [31:0] second_out_x,
  input  logic [31:0] second_out_y,
  input  logic [31:0] second_out_z,
  input  logic [1:0]  outcome,
  output int          fail_count,
  output int          pending
);
  import icv_pkg::*;

  typedef struct {
    logic [2:0][31:0] v1;
    logic [2:0][31:0] v2;
    outcome_t         oc;
  } velocity_result_t;

  velocity_result_t new_velocities[$];

  assign pending = new_velocities.size();

  function automatic logic signed [127:0] floor_q16(logic signed [127:0] x);
    return x >>> 16;
  endfunction

  function automatic logic [31:0] clamp_word(logic signed [127:0] x);
    if (x > 128'sd2147483647) return 32'h7fffffff;
    if (x < -128'sd2147483648) return 32'h80000000;
    return x[31:0];
  endfunction

  // Compute the post-contact velocities of one beat
  function automatic velocity_result_t resolve_contact(
      logic [2:0][31:0] v1, logic [2:0][31:0] v2, logic [2:0][17:0] n,
      logic [31:0] im1, logic [31:0] im2);
    velocity_result_t r;
    logic signed [127:0] s1, s2, tq, d, ad, p, a, f1, f2, sum;
    s1 = 0;
    s2 = 0;
    for (int i = 0; i < 3; i++) begin
      s1 += 128'(signed'(v1[i])) * 128'(signed'(n[i]));
      s2 += 128'(signed'(v2[i])) * 128'(signed'(n[i]));
    end
    tq = 128'(speed_tolerance) <<< 16;
    d = s1 - s2;
    ad = d < 0 ? -d : d;
    sum = 128'(im1) + 128'(im2);
    if (s1 >= -tq && s2 <= tq) r.oc = OC_SEPARATING;
    else if (ad <= tq) r.oc = OC_EQUAL;
    else if (sum == 0) r.oc = OC_NO_MASS;
    else r.oc = OC_APPLIED;
    r.v1 = v1;
    r.v2 = v2;
    if (r.oc == OC_APPLIED) begin
      p = floor_q16(-((128'sd65536 + 128'(restitution)) * floor_q16(d)));
      f1 = ((128'(im1) <<< 16) + sum / 2) / sum;
      f2 = ((128'(im2) <<< 16) + sum / 2) / sum;
      for (int i = 0; i < 3; i++) begin
        a = floor_q16(p * 128'(signed'(n[i])));
        r.v1[i] = clamp_word(128'(signed'(v1[i])) + floor_q16(a * f1));
        r.v2[i] = clamp_word(128'(signed'(v2[i])) - floor_q16(a * f2));
      end
    end
    return r;
  endfunction

  // Predict on accepted contacts, compare on accepted results
  always @(posedge clk) begin
    velocity_result_t want;
    logic [2:0][31:0] g1, g2;
    if (rst) begin
      fail_count <= 0;
      new_velocities.delete();
    end else begin
      if (in_valid && !in_stall)
        new_velocities.insert(new_velocities.size(), resolve_contact(
          {first_vel_z, first_vel_y, first_vel_x},
          {second_vel_z, second_vel_y, second_vel_x},
          {normal_z, normal_y, normal_x}, first_inv_mass, second_inv_mass));
      if (out_valid && !out_stall) begin
        g1 = {first_out_z, first_out_y, first_out_x};
        g2 = {second_out_z, second_out_y, second_out_x};
        if (new_velocities.size() == 0) begin
          if (fail_count < 10) $display("unexpected result beat: %h %h %0d", g1, g2, outcome);
          fail_count <= fail_count + 1;
        end else begin
          want = new_velocities.pop_front();
          if (want.v1 !== g1 || want.v2 !== g2 || want.oc !== outcome) begin
            if (fail_count < 10)
              $display("mismatch: exp %h %h %0d got %h %h %0d",
                       want.v1, want.v2, want.oc, g1, g2, outcome);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives contacts into the impulse collision velocity block under several
// register settings: a directed set of corner contacts, then random contacts
// with random gaps and output stalls, and reports the verdict.
// ----------------------------------------------------------------------------
module tb;
  import icv_pkg::*;

  localparam logic [2:0] ADDR_RESTITUTION = 3'd0;
  localparam logic [2:0] ADDR_TOLERANCE   = 3'd4;
  localparam int LIMIT = 400000;

  logic clk = 0, rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [2:0] paddr = 0;
  logic [31:0] pwdata = 0, prdata;
  logic pready;
  logic in_valid = 0, in_stall, out_valid, out_stall = 0;
  logic [31:0] fvx = 0, fvy = 0, fvz = 0, svx = 0, svy = 0, svz = 0;
  logic [17:0] nx = 0, ny = 0, nz = 0;
  logic [31:0] im1 = 0, im2 = 0;
  logic [31:0] fox, foy, foz, sox, soy, soz;
  logic [1:0] oc;
  logic [17:0] restitution_shadow = 18'd65536;
  logic [30:0] tolerance_shadow = 0;
  int fail_count, pending, cycles = 0, hold_off = 0;
  bit calm = 0;
  bit hold_req = 0, hold_done = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  impulse_collision_velocity u_dut (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid, .in_stall,
    .first_vel_x(fvx), .first_vel_y(fvy), .first_vel_z(fvz),
    .second_vel_x(svx), .second_vel_y(svy), .second_vel_z(svz),
    .normal_x(nx), .normal_y(ny), .normal_z(nz),
    .first_inv_mass(im1), .second_inv_mass(im2),
    .out_valid, .out_stall,
    .first_out_x(fox), .first_out_y(foy), .first_out_z(foz),
    .second_out_x(sox), .second_out_y(soy), .second_out_z(soz), .outcome(oc));

  icv_checker u_chk (
    .clk, .rst, .restitution(restitution_shadow), .speed_tolerance(tolerance_shadow),
    .in_valid, .in_stall,
    .first_vel_x(fvx), .first_vel_y(fvy), .first_vel_z(fvz),
    .second_vel_x(svx), .second_vel_y(svy), .second_vel_z(svz),
    .normal_x(nx), .normal_y(ny), .normal_z(nz),
    .first_inv_mass(im1), .second_inv_mass(im2),
    .out_valid, .out_stall,
    .first_out_x(fox), .first_out_y(foy), .first_out_z(foz),
    .second_out_x(sox), .second_out_y(soy), .second_out_z(soz), .outcome(oc),
    .fail_count, .pending);

  // Stall the result side at random, or for a long hold-off
  always @(posedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_stall <= 1;
    end else if (hold_req && !hold_done) begin
      hold_off <= 150;
      hold_done <= 1;
      out_stall <= 1;
    end else begin
      out_stall <= calm ? 1'b0 : ($urandom_range(99) < 38);
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
    @(posedge clk);
    psel <= 1; pwrite <= 1; paddr <= addr; pwdata <= data;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  // Wait for every result, then let the pipeline drain
  task automatic drain();
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic apply_settings(input logic [17:0] e, input logic [30:0] tol);
    drain();
    reg_write(ADDR_RESTITUTION, 32'(e));
    reg_write(ADDR_TOLERANCE, 32'(tol));
    restitution_shadow = e;
    tolerance_shadow = tol;
  endtask

  function automatic logic [31:0] any_word();
    case ($urandom_range(5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom;
      default: return 32'($signed($urandom_range(2000000)) - 1000000);
    endcase
  endfunction

  function automatic logic [17:0] any_normal();
    case ($urandom_range(5))
      0: return 18'h1ffff;
      1: return 18'h20000;
      2: return 18'($urandom);
      default: return 18'($signed($urandom_range(131072)) - 65536);
    endcase
  endfunction

  function automatic logic [31:0] any_mass();
    case ($urandom_range(6))
      0: return 0;
      1: return 32'hffffffff;
      2: return $urandom;
      default: return $urandom_range(200000);
    endcase
  endfunction

  // Offer one beat, holding it until accepted
  task automatic send(input logic [31:0] a, b, c, d, e, f,
                      input logic [17:0] g, h, k, input logic [31:0] m1, m2);
    while (!calm && $urandom_range(99) < 38) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    fvx <= a; fvy <= b; fvz <= c; svx <= d; svy <= e; svz <= f;
    nx <= g; ny <= h; nz <= k; im1 <= m1; im2 <= m2;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_random();
    send(any_word(), any_word(), any_word(), any_word(), any_word(), any_word(),
         any_normal(), any_normal(), any_normal(), any_mass(), any_mass());
  endtask

  task automatic idle_input();
    in_valid <= 0;
    @(posedge clk);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 0;
    // Directed corners at reset settings
    send(32'h00010000, 0, 0, 0, 0, 0, 18'h10000, 0, 0, 32'h10000, 32'h10000);
    send(32'hffff0000, 0, 0, 0, 0, 0, 18'h10000, 0, 0, 32'h10000, 32'h10000);
    send(32'hffff0000, 0, 0, 0, 0, 0, 18'h10000, 0, 0, 32'h10000, 0);
    send(32'hffff0000, 0, 0, 32'hffff0000, 0, 0, 18'h10000, 0, 0, 1, 1);
    send(32'hffff0000, 0, 0, 0, 0, 0, 18'h10000, 0, 0, 0, 0);
    send(32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
         32'h7fffffff, 18'h1ffff, 18'h1ffff, 18'h1ffff, 32'hffffffff, 32'hffffffff);
    send(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000,
         32'h80000000, 18'h20000, 18'h20000, 18'h20000, 32'hffffffff, 0);
    send(32'h80000000, 0, 0, 32'h7fffffff, 0, 0, 18'h1ffff, 0, 0, 0, 32'hffffffff);
    send(0, 32'hfff00000, 0, 0, 32'h00100000, 0, 0, 18'h0b505, 18'h3b505, 5, 7);
    idle_input();
    // Extremes of both registers
    apply_settings(18'h3ffff, 31'h7fffffff);
    send(32'hffff0000, 0, 0, 0, 0, 0, 18'h10000, 0, 0, 32'h10000, 0);
    send(32'h80000000, 0, 0, 32'h7fffffff, 0, 0, 18'h1ffff, 0, 0, 3, 9);
    idle_input();
    apply_settings(0, 31'd1);
    send(32'hffff0000, 0, 0, 32'h0000ffff, 0, 0, 18'h10000, 0, 0, 1, 2);
    send(32'hffff0000, 0, 0, 0, 0, 0, 18'h10000, 0, 0, 0, 0);
    idle_input();
    apply_settings(18'h20000, 31'd3000);
    // Random part over several settings
    for (int phase = 0; phase < 4; phase++) begin
      for (int i = 0; i < 110; i++) begin
        calm = (phase == 1 && i >= 20 && i < 60);
        if (phase == 2 && i == 10) hold_req = 1;
        send_random();
      end
      calm = 0;
      idle_input();
      case (phase)
        0: apply_settings(18'($urandom_range(131072)), 31'($urandom_range(65536)));
        1: apply_settings(18'd65536, 0);
        2: apply_settings(18'($urandom), 31'($urandom));
        default: ;
      endcase
    end
    drain();
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
